// ----- rtl/core/pvm_pkg.sv -----
// Shared constants and types for the pose to view matrix block.
package pvm_pkg;

    localparam int QW      = 16;
    localparam int PW      = 32;
    localparam int SQW     = 32;
    localparam int NW      = 34;
    localparam int N2W     = 33;
    localparam int MAGW    = 33;
    localparam int DW      = 34;
    localparam int QBITS   = 15;
    localparam int RW      = 49;
    localparam int VW      = 16;
    localparam int PRODW   = 48;
    localparam int SUMW    = 50;
    localparam int RNDW    = 36;
    localparam int TW      = 37;
    localparam int LANES   = 9;
    localparam int AXES    = 3;
    localparam int QDEPTH  = 4;
    localparam int QAW     = 2;
    localparam int ONE_Q14 = 16384;
    localparam int HALF_Q14 = 8192;
    localparam int FRAC    = 14;
    localparam int SCALE   = 15;

    localparam logic signed [TW-1:0] SAT_MAX = TW'(64'sd2147483647);
    localparam logic signed [TW-1:0] SAT_MIN = -TW'(64'sd2147483648);

    typedef struct packed {
        logic                       zero;
        logic [N2W-1:0]             n2;
        logic [LANES-1:0][NW-1:0]   num;
        logic [AXES-1:0][PW-1:0]    pos;
    } pvm_item_t;

endpackage

// ----- rtl/core/pose_to_view_matrix.sv -----
// Top level: head pose to view rotation and translation.
// Throughput: one pose per cycle unless stalled; the divider pipeline sets the latency.
// A 4-entry queue lets the front end keep taking poses while the output is stalled.
// Reset clears only valid flags and queue pointers and count; no result state is kept.
module pose_to_view_matrix
    import pvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pose_valid,
    output logic                 pose_stall,
    input  logic signed [QW-1:0] quat_w,
    input  logic signed [QW-1:0] quat_x,
    input  logic signed [QW-1:0] quat_y,
    input  logic signed [QW-1:0] quat_z,
    input  logic signed [PW-1:0] pos_x,
    input  logic signed [PW-1:0] pos_y,
    input  logic signed [PW-1:0] pos_z,
    output logic                 view_valid,
    input  logic                 view_stall,
    output logic signed [VW-1:0] view_r00,
    output logic signed [VW-1:0] view_r01,
    output logic signed [VW-1:0] view_r02,
    output logic signed [VW-1:0] view_r10,
    output logic signed [VW-1:0] view_r11,
    output logic signed [VW-1:0] view_r12,
    output logic signed [VW-1:0] view_r20,
    output logic signed [VW-1:0] view_r21,
    output logic signed [VW-1:0] view_r22,
    output logic signed [PW-1:0] view_tx,
    output logic signed [PW-1:0] view_ty,
    output logic signed [PW-1:0] view_tz
);

    logic      q_full;
    logic      q_empty;
    logic      q_push;
    logic      q_pop;
    pvm_item_t q_din;
    pvm_item_t q_dout;

    pvm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pose_valid (pose_valid),
        .pose_stall (pose_stall),
        .quat_w     (quat_w),
        .quat_x     (quat_x),
        .quat_y     (quat_y),
        .quat_z     (quat_z),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (q_din)
    );

    pvm_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    pvm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_item     (q_dout),
        .q_pop      (q_pop),
        .view_valid (view_valid),
        .view_stall (view_stall),
        .view_r00   (view_r00),
        .view_r01   (view_r01),
        .view_r02   (view_r02),
        .view_r10   (view_r10),
        .view_r11   (view_r11),
        .view_r12   (view_r12),
        .view_r20   (view_r20),
        .view_r21   (view_r21),
        .view_r22   (view_r22),
        .view_tx    (view_tx),
        .view_ty    (view_ty),
        .view_tz    (view_tz)
    );

endmodule

// ----- rtl/core/pvm_front.sv -----
// Front end: quaternion products, norm, rotation numerators and zero check.
module pvm_front
    import pvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pose_valid,
    output logic                 pose_stall,
    input  logic signed [QW-1:0] quat_w,
    input  logic signed [QW-1:0] quat_x,
    input  logic signed [QW-1:0] quat_y,
    input  logic signed [QW-1:0] quat_z,
    input  logic signed [PW-1:0] pos_x,
    input  logic signed [PW-1:0] pos_y,
    input  logic signed [PW-1:0] pos_z,
    input  logic                 q_full,
    output logic                 q_push,
    output pvm_item_t            q_item
);

    logic                    f1_vld_reg;
    logic                    f2_vld_reg;
    logic                    en_f;
    logic signed [SQW-1:0]   ww_reg, xx_reg, yy_reg, zz_reg;
    logic signed [SQW-1:0]   xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    logic [AXES-1:0][PW-1:0] pos1_reg;
    pvm_item_t               item_reg;
    pvm_item_t               item_next;
    logic signed [NW-1:0]    ww_e, xx_e, yy_e, zz_e;
    logic signed [NW-1:0]    xy_e, zw_e, xz_e, yw_e, yz_e, xw_e;
    logic signed [NW-1:0]    n2_e;

    assign en_f       = !(f2_vld_reg && q_full);
    assign pose_stall = !en_f;
    assign q_push     = f2_vld_reg && !q_full;
    assign q_item     = item_reg;

    always_comb
    begin
        ww_e = NW'(ww_reg);
        xx_e = NW'(xx_reg);
        yy_e = NW'(yy_reg);
        zz_e = NW'(zz_reg);
        xy_e = NW'(xy_reg);
        zw_e = NW'(zw_reg);
        xz_e = NW'(xz_reg);
        yw_e = NW'(yw_reg);
        yz_e = NW'(yz_reg);
        xw_e = NW'(xw_reg);
        n2_e = ww_e + xx_e + yy_e + zz_e;
        item_next.n2     = n2_e[N2W-1:0];
        item_next.zero   = (n2_e == '0);
        item_next.num[0] = ww_e + xx_e - yy_e - zz_e;
        item_next.num[1] = (xy_e + zw_e) <<< 1;
        item_next.num[2] = (xz_e - yw_e) <<< 1;
        item_next.num[3] = (xy_e - zw_e) <<< 1;
        item_next.num[4] = ww_e - xx_e + yy_e - zz_e;
        item_next.num[5] = (yz_e + xw_e) <<< 1;
        item_next.num[6] = (xz_e + yw_e) <<< 1;
        item_next.num[7] = (yz_e - xw_e) <<< 1;
        item_next.num[8] = ww_e - xx_e - yy_e + zz_e;
        item_next.pos    = pos1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end
        else if (en_f)
        begin
            f1_vld_reg <= pose_valid;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_f)
        begin
            ww_reg      <= quat_w * quat_w;
            xx_reg      <= quat_x * quat_x;
            yy_reg      <= quat_y * quat_y;
            zz_reg      <= quat_z * quat_z;
            xy_reg      <= quat_x * quat_y;
            zw_reg      <= quat_z * quat_w;
            xz_reg      <= quat_x * quat_z;
            yw_reg      <= quat_y * quat_w;
            yz_reg      <= quat_y * quat_z;
            xw_reg      <= quat_x * quat_w;
            pos1_reg[0] <= pos_x;
            pos1_reg[1] <= pos_y;
            pos1_reg[2] <= pos_z;
            item_reg    <= item_next;
        end
    end

endmodule

// ----- rtl/core/pvm_queue.sv -----
// Small register FIFO between the front and back ends.
module pvm_queue
    import pvm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  pvm_item_t din,
    input  logic      pop,
    output pvm_item_t dout,
    output logic      full,
    output logic      empty
);

    pvm_item_t        mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     count_reg;

    assign full  = (count_reg == (QAW+1)'(QDEPTH));
    assign empty = (count_reg == '0);
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/core/pvm_back.sv -----
// Back end: pipelined rounding dividers, view rotation and translation.
module pvm_back
    import pvm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_empty,
    input  pvm_item_t            q_item,
    output logic                 q_pop,
    output logic                 view_valid,
    input  logic                 view_stall,
    output logic signed [VW-1:0] view_r00,
    output logic signed [VW-1:0] view_r01,
    output logic signed [VW-1:0] view_r02,
    output logic signed [VW-1:0] view_r10,
    output logic signed [VW-1:0] view_r11,
    output logic signed [VW-1:0] view_r12,
    output logic signed [VW-1:0] view_r20,
    output logic signed [VW-1:0] view_r21,
    output logic signed [VW-1:0] view_r22,
    output logic signed [PW-1:0] view_tx,
    output logic signed [PW-1:0] view_ty,
    output logic signed [PW-1:0] view_tz
);

    localparam int VS  = QBITS + 1;
    localparam int PS  = QBITS + 2;
    localparam int SS  = QBITS + 3;
    localparam int OS  = QBITS + 4;
    localparam int NST = QBITS + 5;

    logic                    en_b;
    logic [NST-1:0]          vld_reg;

    logic [RW-1:0]           rem_reg  [QBITS+1][LANES];
    logic [QBITS-1:0]        quo_reg  [QBITS+1][LANES];
    logic [LANES-1:0]        neg_reg  [QBITS+1];
    logic [DW-1:0]           den2_reg [QBITS+1];
    logic                    zero_reg [QBITS+1];
    logic [AXES-1:0][PW-1:0] pos_reg  [QBITS+1];

    logic [RW-1:0]           rem_next [QBITS+1][LANES];
    logic [QBITS-1:0]        quo_next [QBITS+1][LANES];
    logic [LANES-1:0]        neg0_next;

    logic signed [VW-1:0]    v_reg  [LANES];
    logic signed [VW-1:0]    vp_reg [LANES];
    logic signed [VW-1:0]    vs_reg [LANES];
    logic signed [VW-1:0]    vo_reg [LANES];
    logic signed [VW-1:0]    v_next [LANES];
    logic [AXES-1:0][PW-1:0] posv_reg;
    logic signed [PRODW-1:0] prod_reg [LANES];
    logic signed [SUMW-1:0]  sum_reg  [AXES];
    logic signed [PW-1:0]    t_reg    [AXES];
    logic signed [PW-1:0]    t_next   [AXES];

    assign en_b       = !(vld_reg[OS] && view_stall);
    assign q_pop      = en_b && !q_empty;
    assign view_valid = vld_reg[OS];

    always_comb
    begin
        logic signed [NW-1:0] numv;
        logic [MAGW-1:0]      mag;
        logic [RW-1:0]        trial;
        logic                 ge;
        for (int l = 0; l < LANES; l++)
        begin
            numv         = $signed(q_item.num[l]);
            neg0_next[l] = numv[NW-1];
            mag          = neg0_next[l] ? MAGW'(-numv) : MAGW'(numv);
            rem_next[0][l] = (RW'(mag) << SCALE) + RW'(q_item.n2);
            quo_next[0][l] = '0;
        end
        for (int s = 1; s <= QBITS; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial          = RW'(den2_reg[s-1]) << (QBITS - s);
                ge             = (rem_reg[s-1][l] >= trial);
                rem_next[s][l] = ge ? (rem_reg[s-1][l] - trial) : rem_reg[s-1][l];
                quo_next[s][l] = {quo_reg[s-1][l][QBITS-2:0], ge};
            end
        end
    end

    always_comb
    begin
        logic signed [VW-1:0] qv;
        for (int l = 0; l < LANES; l++)
        begin
            qv = $signed({1'b0, quo_reg[QBITS][l]});
            if (zero_reg[QBITS])
            begin
                v_next[l] = (l == 0 || l == 4 || l == 8) ? VW'(ONE_Q14) : '0;
            end
            else
            begin
                v_next[l] = neg_reg[QBITS][l] ? -qv : qv;
            end
        end
    end

    always_comb
    begin
        logic               sneg;
        logic [SUMW-1:0]    smag;
        logic [RNDW-1:0]    rq;
        logic signed [TW-1:0] tv;
        for (int r = 0; r < AXES; r++)
        begin
            sneg = sum_reg[r][SUMW-1];
            smag = sneg ? SUMW'(-sum_reg[r]) : SUMW'(sum_reg[r]);
            rq   = RNDW'((smag + SUMW'(HALF_Q14)) >> FRAC);
            tv   = sneg ? $signed({1'b0, rq}) : -$signed({1'b0, rq});
            if (tv > SAT_MAX)
            begin
                t_next[r] = PW'(SAT_MAX);
            end
            else if (tv < SAT_MIN)
            begin
                t_next[r] = PW'(SAT_MIN);
            end
            else
            begin
                t_next[r] = PW'(tv);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en_b)
        begin
            vld_reg <= {vld_reg[NST-2:0], !q_empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_b)
        begin
            den2_reg[0] <= {q_item.n2, 1'b0};
            zero_reg[0] <= q_item.zero;
            pos_reg[0]  <= q_item.pos;
            neg_reg[0]  <= neg0_next;
            for (int l = 0; l < LANES; l++)
            begin
                rem_reg[0][l] <= rem_next[0][l];
                quo_reg[0][l] <= quo_next[0][l];
            end
            for (int s = 1; s <= QBITS; s++)
            begin
                den2_reg[s] <= den2_reg[s-1];
                zero_reg[s] <= zero_reg[s-1];
                pos_reg[s]  <= pos_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    quo_reg[s][l] <= quo_next[s][l];
                end
            end
            posv_reg <= pos_reg[QBITS];
            for (int l = 0; l < LANES; l++)
            begin
                v_reg[l]  <= v_next[l];
                vp_reg[l] <= v_reg[l];
                vs_reg[l] <= vp_reg[l];
                vo_reg[l] <= vs_reg[l];
            end
            for (int r = 0; r < AXES; r++)
            begin
                for (int j = 0; j < AXES; j++)
                begin
                    prod_reg[r*AXES+j] <= PRODW'(v_reg[r*AXES+j])
                                        * PRODW'($signed(posv_reg[j]));
                end
                sum_reg[r] <= SUMW'(prod_reg[r*AXES]) + SUMW'(prod_reg[r*AXES+1])
                            + SUMW'(prod_reg[r*AXES+2]);
                t_reg[r]   <= t_next[r];
            end
        end
    end

    assign view_r00 = vo_reg[0];
    assign view_r01 = vo_reg[1];
    assign view_r02 = vo_reg[2];
    assign view_r10 = vo_reg[3];
    assign view_r11 = vo_reg[4];
    assign view_r12 = vo_reg[5];
    assign view_r20 = vo_reg[6];
    assign view_r21 = vo_reg[7];
    assign view_r22 = vo_reg[8];
    assign view_tx  = t_reg[0];
    assign view_ty  = t_reg[1];
    assign view_tz  = t_reg[2];

endmodule
